// ===== rtl/lpi_pkg.sv =====
package lpi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_PAST  = 3'd1;
	localparam logic [2:0] STAT_UNDER = 3'd2;
	localparam logic [2:0] STAT_FULL  = 3'd3;
	localparam logic [2:0] STAT_EQUAL = 3'd4;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic [31:0]        tick;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               on;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/lpi_ram.sv =====
module lpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry a cycle, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/lpi_div.sv =====
module lpi_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        take;

	// form one quotient bit per cycle
	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift numerator through, collect quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[62:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/laser_path_interpolator.sv =====
// Path table with time lookup. An append (command 0) stores a point at the end
// of the table and answers with status 0, or 3 when the table is full. A query
// (command 1) scans the table in storage order, one entry per cycle through the
// single table memory port, for the first point whose time is at least the query
// time, then interpolates x and y one after the other on a shared bit-serial
// 64/32 divider. A query with under two entries ends without a scan, an
// equal-times query still scans but skips the divider, and a query past the end
// scans the whole table. One item is in work at a time; a finished result waits
// in the output register while the next item is accepted.
module laser_path_interpolator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [31:0]        time_tick,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [15:0]        power_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic               laser_on,
	output logic [2:0]         status
);

	import lpi_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DISP   = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_FETCHB = 4'd3;
	localparam logic [3:0] ST_CHECK  = 4'd4;
	localparam logic [3:0] ST_MAG    = 4'd5;
	localparam logic [3:0] ST_MUL    = 4'd6;
	localparam logic [3:0] ST_DIVGO  = 4'd7;
	localparam logic [3:0] ST_DIVW   = 4'd8;
	localparam logic [3:0] ST_SAT    = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              cmd_q;
	logic [31:0]       t_q;
	entry_t            new_q;
	logic [ADDR_W-1:0] chk_q;
	entry_t            pa_q;
	entry_t            pb_q;
	entry_t            prev_q;
	logic              axis_q;
	logic              neg_q;
	logic [31:0]       ud_q;
	logic [31:0]       ue_q;
	logic [31:0]       uf_q;
	logic [63:0]       prod_q;
	logic signed [31:0] rx_q;
	logic signed [31:0] ry_q;
	logic              ron_q;
	logic [2:0]        rstat_q;
	logic              ovalid_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	entry_t            ram_rd;
	logic              div_start;
	logic              div_done;
	logic [63:0]       div_quo;
	logic              in_acc;
	logic              out_free;
	logic signed [32:0] f_w;
	logic signed [32:0] d_w;
	logic signed [32:0] e_w;
	logic signed [31:0] base_w;
	logic signed [31:0] end_w;
	logic signed [35:0] sum_w;
	logic signed [31:0] sat_w;
	logic [CNT_W-1:0]  last_w;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !ovalid_q || !out_stall;
	assign last_w   = count_q - CNT_W'(1);

	// drive the table port: write on an append when the table is not full, scan reads otherwise
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = chk_q;
		if (state_q == ST_DISP) begin
			if (cmd_q == CMD_APPEND) begin
				ram_we   = (count_q != FULL_CNT);
				ram_addr = count_q[ADDR_W-1:0];
			end else begin
				ram_addr = '0;
			end
		end else if (state_q == ST_SCAN) begin
			ram_addr = (chk_q == ADDR_W'(0) && ram_rd.tick >= t_q) ? ADDR_W'(1)
			                                                       : chk_q + ADDR_W'(1);
		end
	end

	lpi_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(new_q),
		.rdata(ram_rd)
	);

	assign div_start = (state_q == ST_DIVGO);

	lpi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q),
		.den   (uf_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// differences for the current axis
	assign base_w = axis_q ? pa_q.y : pa_q.x;
	assign end_w  = axis_q ? pb_q.y : pb_q.x;
	assign f_w    = $signed({1'b0, pb_q.tick}) - $signed({1'b0, pa_q.tick});
	assign d_w    = $signed({end_w[31], end_w}) - $signed({base_w[31], base_w});
	assign e_w    = $signed({1'b0, t_q}) - $signed({1'b0, pa_q.tick});

	// add the quotient to the base and clamp
	always_comb begin
		sum_w = neg_q ? (36'(base_w) - $signed({2'b00, div_quo[33:0]}))
		              : (36'(base_w) + $signed({2'b00, div_quo[33:0]}));
		if (div_quo > 64'h2_0000_0000) begin
			sat_w = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (sum_w > 36'sh0_7fff_ffff) begin
			sat_w = 32'sh7fff_ffff;
		end else if (sum_w < -36'sh0_8000_0000) begin
			sat_w = 32'sh8000_0000;
		end else begin
			sat_w = sum_w[31:0];
		end
	end

	// sequence one item at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (cmd_q == CMD_APPEND) begin
						if (count_q != FULL_CNT) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_FIN;
					end else if (count_q < CNT_W'(2)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ram_rd.tick >= t_q) begin
						state_q <= (chk_q == ADDR_W'(0)) ? ST_FETCHB : ST_CHECK;
					end else if (CNT_W'(chk_q) == last_w) begin
						state_q <= ST_FIN;
					end
				end
				ST_FETCHB: state_q <= ST_CHECK;
				ST_CHECK:  state_q <= (f_w == '0) ? ST_FIN : ST_MAG;
				ST_MAG:    state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_DIVGO;
				ST_DIVGO:  state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT:    state_q <= axis_q ? ST_FIN : ST_MAG;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q      <= command;
				t_q        <= time_tick;
				new_q.tick <= time_tick;
				new_q.x    <= coord_x;
				new_q.y    <= coord_y;
				new_q.on   <= (power_level == 16'd1);
			end
			ST_DISP: begin
				rx_q    <= '0;
				ry_q    <= '0;
				ron_q   <= 1'b0;
				chk_q   <= '0;
				axis_q  <= 1'b0;
				if (cmd_q == CMD_APPEND) begin
					rstat_q <= (count_q == FULL_CNT) ? STAT_FULL : STAT_OK;
				end else begin
					rstat_q <= (count_q < CNT_W'(2)) ? STAT_UNDER : STAT_OK;
				end
			end
			ST_SCAN: begin
				prev_q <= ram_rd;
				if (ram_rd.tick >= t_q) begin
					pa_q <= ram_rd;
					pb_q <= prev_q;
				end else if (CNT_W'(chk_q) == last_w) begin
					rstat_q <= STAT_PAST;
				end else begin
					chk_q <= chk_q + ADDR_W'(1);
				end
			end
			ST_FETCHB: pb_q <= ram_rd;
			ST_CHECK: begin
				ron_q <= pa_q.on && pb_q.on;
				if (f_w == '0) begin
					rx_q    <= pa_q.x;
					ry_q    <= pa_q.y;
					rstat_q <= STAT_EQUAL;
				end
			end
			ST_MAG: begin
				neg_q <= d_w[32] ^ e_w[32] ^ f_w[32];
				ud_q  <= d_w[32] ? 32'(-d_w) : d_w[31:0];
				ue_q  <= e_w[32] ? 32'(-e_w) : e_w[31:0];
				uf_q  <= f_w[32] ? 32'(-f_w) : f_w[31:0];
			end
			ST_MUL: prod_q <= 64'(ud_q) * 64'(ue_q);
			ST_SAT: begin
				if (axis_q) begin
					ry_q <= sat_w;
				end else begin
					rx_q <= sat_w;
				end
				axis_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// hold the result until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			pos_x    <= rx_q;
			pos_y    <= ry_q;
			laser_on <= ron_q;
			status   <= rstat_q;
		end
	end

	assign out_valid = ovalid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond table depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_PAST || status == STAT_UNDER || status == STAT_FULL)
		|-> (pos_x == 32'sd0 && pos_y == 32'sd0 && !laser_on))
		else $error("error result carries nonzero fields");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> ##63 !div_done)
		else $error("divider finished early");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import lpi_pkg::*;

	localparam int  HALF_PERIOD = 6;
	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  DRAIN_WAIT  = 1400;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               on;
		logic [2:0]         st;
	} position_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               command = CMD_APPEND;
	logic [31:0]        time_tick = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic [15:0]        power_level = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic               laser_on;
	logic [2:0]         status;

	// shadow copy of the path table
	logic [31:0]        path_tick [TABLE_DEPTH];
	logic signed [31:0] path_x [TABLE_DEPTH];
	logic signed [31:0] path_y [TABLE_DEPTH];
	logic               path_on [TABLE_DEPTH];
	int                 path_count = 0;
	logic [31:0]        last_tick = '0;

	position_t pending_pos[$];
	int        mismatches = 0;
	int        cycles = 0;
	bit        idle_on = 1'b1;
	int        hold_len = 0;

	laser_path_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .time_tick(time_tick), .coord_x(coord_x),
		.coord_y(coord_y), .power_level(power_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .laser_on(laser_on), .status(status)
	);

	always #HALF_PERIOD clk = ~clk;

	// base + trunc(d*e/f), saturated to 32 bits
	function automatic logic signed [31:0] lerp_sat(logic signed [31:0] base,
			logic signed [32:0] d, logic signed [32:0] e, logic signed [32:0] f);
		logic              neg;
		logic [32:0]       ud, ue, uf;
		logic [65:0]       q;
		logic signed [67:0] r;
		neg = d[32] ^ e[32] ^ f[32];
		ud = d[32] ? -d : d;
		ue = e[32] ? -e : e;
		uf = f[32] ? -f : f;
		q = ({33'b0, ud} * {33'b0, ue}) / {33'b0, uf};
		if (q > 66'h2_0000_0000)
			return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		r = neg ? base - $signed({2'b00, q}) : base + $signed({2'b00, q});
		if (r > 68'sh7fff_ffff)
			return 32'sh7fff_ffff;
		if (r < -68'sh8000_0000)
			return 32'sh8000_0000;
		return r[31:0];
	endfunction

	// update the shadow table and work out the position for one transfer
	function automatic position_t track_path(logic cmd, logic [31:0] t,
			logic signed [31:0] x, logic signed [31:0] y, logic [15:0] p);
		position_t          res;
		int                 a, b;
		logic signed [32:0] f, e;
		res = '{0, 0, 1'b0, STAT_OK};
		if (cmd == CMD_APPEND) begin
			if (path_count >= TABLE_DEPTH) begin
				res.st = STAT_FULL;
			end else begin
				path_tick[path_count] = t;
				path_x[path_count] = x;
				path_y[path_count] = y;
				path_on[path_count] = (p == 16'd1);
				path_count++;
			end
			return res;
		end
		if (path_count < 2) begin
			res.st = STAT_UNDER;
			return res;
		end
		a = path_count;
		for (int i = 0; i < path_count; i++)
			if (path_tick[i] >= t) begin
				a = i;
				break;
			end
		if (a >= path_count) begin
			res.st = STAT_PAST;
			return res;
		end
		b = (a != 0) ? a - 1 : 1;
		res.on = path_on[a] && path_on[b];
		f = $signed({1'b0, path_tick[b]}) - $signed({1'b0, path_tick[a]});
		if (f == 0) begin
			res.x = path_x[a];
			res.y = path_y[a];
			res.st = STAT_EQUAL;
			return res;
		end
		e = $signed({1'b0, t}) - $signed({1'b0, path_tick[a]});
		res.x = lerp_sat(path_x[a], path_x[b] - path_x[a], e, f);
		res.y = lerp_sat(path_y[a], path_y[b] - path_y[a], e, f);
		return res;
	endfunction

	// offer one item, hold it until the transfer, record the expected position
	task automatic send_item(logic cmd, logic [31:0] t, logic signed [31:0] x,
			logic signed [31:0] y, logic [15:0] p);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		time_tick <= t;
		coord_x <= x;
		coord_y <= y;
		power_level <= p;
		do @(posedge clk); while (in_stall);
		pending_pos.insert(pending_pos.size(), track_path(cmd, t, x, y, p));
	endtask

	task automatic append_point(logic [31:0] t, logic signed [31:0] x,
			logic signed [31:0] y, logic [15:0] p);
		send_item(CMD_APPEND, t, x, y, p);
	endtask

	task automatic query_at(logic [31:0] t);
		send_item(CMD_QUERY, t, $urandom, $urandom, 16'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_pos.size() != 0) @(posedge clk);
	endtask

	// pick a coordinate: mostly moderate, sometimes full range
	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $signed($urandom_range(0, 200000)) - 100000;
	endfunction

	// append the next point, mostly later in time than the last one
	task automatic append_next();
		logic [31:0] t;
		logic [15:0] p;
		case ($urandom_range(0, 19))
			0:       t = $urandom;
			1, 2:    t = last_tick;
			default: t = last_tick + $urandom_range(1, 1 << 20);
		endcase
		last_tick = t;
		p = ($urandom_range(0, 9) < 7) ? 16'd1 : 16'($urandom);
		append_point(t, rand_coord(), rand_coord(), p);
	endtask

	// query near a stored time, exactly on one, or anywhere
	task automatic query_near();
		logic [31:0] t;
		int          k;
		k = (path_count > 0) ? $urandom_range(0, path_count - 1) : 0;
		case ($urandom_range(0, 9))
			0, 1:    t = $urandom;
			2, 3:    t = path_tick[k];
			default: t = path_tick[k] + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
		query_at(t);
	endtask

	task automatic test_short_table();
		query_at(32'd0);
		append_point(32'd1000, 32'sh8000_0000, 32'sh7fff_ffff, 16'd1);
		query_at(32'hffff_ffff);
		append_point(32'd1000, 32'sh7fff_ffff, 32'sh8000_0000, 16'd1);
		last_tick = 32'd1000;
	endtask

	task automatic test_cases();
		query_at(32'd5);
		query_at(32'd1000);
		append_point(32'd3000, 32'sh7fff_ffff, 32'sh8000_0000, 16'd1);
		query_at(32'd2000);
		query_at(32'd2999);
		query_at(32'hffff_ffff);
		append_point(32'hffff_ffff, -32'sd5, 32'sd5, 16'd2);
		query_at(32'hffff_ffff);
		query_at(32'h8000_0000);
		append_point(32'd0, 32'sd7, -32'sd7, 16'hffff);
		query_at(32'd0);
		append_point(32'd4000, 32'sd0, 32'sd0, 16'd0);
		query_at(32'd3500);
		last_tick = 32'd4000;
	endtask

	task automatic test_backpressure();
		hold_len = 400;
		idle_on = 1'b0;
		for (int i = 0; i < 10; i++)
			append_next();
		idle_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_paths(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 300 == 150)
				idle_on = ~idle_on;
			if ($urandom_range(0, 9) < 3)
				append_next();
			else
				query_near();
		end
		idle_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_full_table();
		while (path_count < TABLE_DEPTH)
			append_next();
		for (int i = 0; i < 6; i++)
			append_next();
		for (int i = 0; i < 12; i++)
			query_near();
		query_at(last_tick);
		wait_drained();
	endtask

	// receiver: random stall before each result, one long hold when asked
	initial begin
		int w;
		forever begin
			if (hold_len > 0) begin
				w = hold_len;
				hold_len = 0;
			end else begin
				w = idle_on ? $urandom_range(0, 15) : 0;
			end
			if (w > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (w - 1) @(negedge clk);
				@(negedge clk) out_stall <= 1'b0;
			end else begin
				@(negedge clk) out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each transfer with the oldest expected position
	always @(posedge clk) begin
		position_t exp_pos;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d on=%0b st=%0d",
						pos_x, pos_y, laser_on, status);
			end else begin
				exp_pos = pending_pos.pop_front();
				if (pos_x !== exp_pos.x || pos_y !== exp_pos.y
						|| laser_on !== exp_pos.on || status !== exp_pos.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%0d y=%0d on=%0b st=%0d, got x=%0d y=%0d on=%0b st=%0d",
							exp_pos.x, exp_pos.y, exp_pos.on, exp_pos.st,
							pos_x, pos_y, laser_on, status);
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_short_table();
		test_cases();
		wait_drained();
		test_backpressure();
		test_random_paths(1300);
		test_full_table();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_pos.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
